### design/vlc_pkg.sv
// Package of shared types, constants and helpers for the viseme level classifier.
`timescale 1ns / 1ps
`default_nettype none
package vlc_pkg;
    localparam int ENERGY_BITS = 24;
    localparam int MAX_LEVELS  = 16;
    localparam int LVL_W       = $clog2(MAX_LEVELS + 1);
    localparam int WE_W        = ENERGY_BITS + 10;
    localparam int SUM_W       = WE_W + 3;
    localparam int NUM_W       = SUM_W + 6;
    localparam int DIVN_W      = NUM_W + LVL_W;
    localparam int DIVD_W      = SUM_W + 5;
    localparam int CNT_W       = $clog2(DIVN_W + 1);
    localparam logic [1:0] REG_NOISE = 2'd0;
    localparam logic [1:0] REG_LEVELS = 2'd1;
    localparam logic [1:0] REG_RATE = 2'd2;
    localparam logic [1:0] REG_HOLD = 2'd3;
    localparam logic [2:0] VIS_AH = 3'd0;

    typedef struct packed {
        logic [2:0]       vis;
        logic             gate;
        logic [DIVN_W-1:0] num;
        logic [DIVD_W-1:0] den;
        logic [31:0]      now;
    } vlc_item_t;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SMOOTH, ST_OUT} vlc_state_t;

    function automatic logic [WE_W-1:0] weigh(input logic [ENERGY_BITS-1:0] e,
                                              input logic [2:0] i);
        logic [9:0] w;
        begin
            case (i)
                3'd0: w = 10'd154;
                3'd1: w = 10'd256;
                3'd2: w = 10'd461;
                3'd3: w = 10'd563;
                default: w = 10'd666;
            endcase
            weigh = WE_W'(e) * WE_W'(w);
        end
    endfunction
endpackage
`default_nettype wire

### design/viseme_level_classifier.sv
// Top level of the viseme level classifier with its configuration registers.
//  channel | handshake         | payload
//  input   | push / full       | five band energies, now_ms
//  result  | empty / pop       | silent, viseme, frame_row, loudness
//  config  | cfg_valid / ready | cfg_index, cfg_data
// The back end takes a transaction from the queue, runs the one-bit-a-cycle restoring
// divider over the 48-bit scaled numerator, steps through a state between division and
// smoothing, and then smooths and loads the result register.
// Ahead of that, the front end registers the weighted energies and then writes the item into the queue.
// Reset clears the smoothing state and loads register defaults.
// A two-entry queue separates front and back; an unpopped result holds the back end.
`timescale 1ns / 1ps
`default_nettype none
module viseme_level_classifier import vlc_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [ENERGY_BITS-1:0] ah_energy,
    input  wire logic [ENERGY_BITS-1:0] ee_energy,
    input  wire logic [ENERGY_BITS-1:0] oh_energy,
    input  wire logic [ENERGY_BITS-1:0] oo_energy,
    input  wire logic [ENERGY_BITS-1:0] th_energy,
    input  wire logic [31:0]            now_ms,
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        silent,
    output logic [2:0]                  viseme,
    output logic [3:0]                  frame_row,
    output logic [4:0]                  loudness,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [25:0]            cfg_data
);
    logic [25:0] noise_reg;
    logic [4:0] levels_reg;
    logic [15:0] rate_reg, hold_reg;
    logic [LVL_W-1:0] top;
    logic q_valid, q_take;
    vlc_item_t q_item;

    assign cfg_ready = 1'b1;
    assign top = levels_reg == 5'd0 ? LVL_W'(1) :
                 (levels_reg > 5'(MAX_LEVELS) ? LVL_W'(MAX_LEVELS) : LVL_W'(levels_reg));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            noise_reg <= '0;
            levels_reg <= 5'd8;
            rate_reg <= 16'd256;
            hold_reg <= 16'd500;
        end
        else if (cfg_valid) begin
            case (cfg_index)
                REG_NOISE:  noise_reg <= cfg_data;
                REG_LEVELS: levels_reg <= cfg_data[4:0];
                REG_RATE:   rate_reg <= cfg_data[15:0];
                REG_HOLD:   hold_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    vlc_front u_front (
        .clk, .rst_n, .e0(ah_energy), .e1(ee_energy), .e2(oh_energy),
        .e3(oo_energy), .e4(th_energy), .now_ms, .push, .full,
        .noise_threshold(noise_reg), .top, .q_valid, .q_item, .q_take
    );

    vlc_back u_back (
        .clk, .rst_n, .q_valid, .q_item, .q_take, .top,
        .decay_rate(rate_reg), .decay_hold_ms(hold_reg), .empty, .pop,
        .silent, .viseme, .frame_row, .loudness
    );
endmodule
`default_nettype wire

### design/vlc_front.sv
// Front end: weighting, viseme choice, level numerator and divisor, and the two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module vlc_front import vlc_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [ENERGY_BITS-1:0] e0,
    input  wire logic [ENERGY_BITS-1:0] e1,
    input  wire logic [ENERGY_BITS-1:0] e2,
    input  wire logic [ENERGY_BITS-1:0] e3,
    input  wire logic [ENERGY_BITS-1:0] e4,
    input  wire logic [31:0]            now_ms,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [25:0]            noise_threshold,
    input  wire logic [LVL_W-1:0]       top,
    output logic                        q_valid,
    output vlc_item_t                   q_item,
    input  wire logic                   q_take
);
    logic [WE_W-1:0] w_reg [5];
    logic [31:0] now_reg;
    logic s1_reg, s1_next, fifo_full;
    logic [SUM_W-1:0] sum;
    logic [2:0] best, runner, vis;
    logic [WE_W-1:0] wb;
    vlc_item_t it;
    logic [1:0] cnt_reg, cnt_next;
    vlc_item_t mem_reg [2];
    logic rd_reg, wr_reg;
    logic do_push;

    assign fifo_full = cnt_reg == 2'd2;
    assign full = s1_reg && fifo_full;
    assign do_push = s1_reg && !fifo_full;
    assign s1_next = push && !full ? 1'b1 : (do_push ? 1'b0 : s1_reg);

    always_ff @(posedge clk) begin
        if (push && !full) begin
            w_reg[0] <= weigh(e0, 3'd0);
            w_reg[1] <= weigh(e1, 3'd1);
            w_reg[2] <= weigh(e2, 3'd2);
            w_reg[3] <= weigh(e3, 3'd3);
            w_reg[4] <= weigh(e4, 3'd4);
            now_reg <= now_ms;
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < 5; i++)
            sum = sum + SUM_W'(w_reg[i]);
        best = 3'd0;
        for (int i = 1; i < 5; i++)
            if (w_reg[i] > w_reg[best]) best = 3'(i);
        runner = 3'd1;
        for (int i = 2; i < 5; i++)
            if (w_reg[i] > w_reg[runner]) runner = 3'(i);
        wb = w_reg[best];
        vis = best;
        if (best == VIS_AH && ({2'b0, w_reg[runner]} << 2) >=
            ({2'b0, w_reg[0]} + ({2'b0, w_reg[0]} << 1)))
            vis = runner;
        it.vis = vis;
        it.gate = sum != '0 && {2'b0, wb} > (36'(noise_threshold) << 8);
        it.num = DIVN_W'((NUM_W'(wb) * NUM_W'(50) - NUM_W'(sum) * NUM_W'(6))
                 * DIVN_W'(top - LVL_W'(1)));
        it.den = DIVD_W'(sum) * DIVD_W'(22);
        it.now = now_reg;
    end

    assign cnt_next = cnt_reg + 2'(do_push) - 2'(q_take);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_reg <= 1'b0;
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else begin
            s1_reg <= s1_next;
            cnt_reg <= cnt_next;
            if (do_push) wr_reg <= !wr_reg;
            if (q_take) rd_reg <= !rd_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) mem_reg[wr_reg] <= it;
    end

    assign q_valid = cnt_reg != 2'd0;
    assign q_item = mem_reg[rd_reg];
endmodule
`default_nettype wire

### design/vlc_back.sv
// Back end: restoring divider, level smoothing, viseme hold and result register.
`timescale 1ns / 1ps
`default_nettype none
module vlc_back import vlc_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire vlc_item_t         q_item,
    output logic                   q_take,
    input  wire logic [LVL_W-1:0]  top,
    input  wire logic [15:0]       decay_rate,
    input  wire logic [15:0]       decay_hold_ms,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   silent,
    output logic [2:0]             viseme,
    output logic [3:0]             frame_row,
    output logic [4:0]             loudness
);
    vlc_state_t st_reg, st_next;
    vlc_item_t it_reg;
    logic [DIVN_W-1:0] quo_reg;
    logic [DIVD_W:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIVD_W:0] trial;
    logic [LVL_W-1:0] raw, cur, lvl_c, sm_reg;
    logic [31:0] dstart_reg, elapsed;
    logic decaying_reg;
    logic [LVL_W-1:0] last_reg;
    logic [2:0] held_reg, vis_c;
    logic [47:0] prod;
    logic [40:0] dec;
    logic full_out_reg;
    logic out_load;
    logic nd, ns;
    logic [31:0] nds;

    assign trial = {rem_reg[DIVD_W-1:0], quo_reg[DIVN_W-1]};
    assign out_load = (st_reg == ST_OUT) && (!full_out_reg || pop);

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:   if (q_valid) st_next = ST_DIV;
            ST_DIV:    if (cnt_reg == CNT_W'(DIVN_W - 1)) st_next = ST_SMOOTH;
            ST_SMOOTH: st_next = ST_OUT;
            ST_OUT:    if (!full_out_reg || pop) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_take = 1'b0;
        unique case (st_reg)
            ST_IDLE: q_take = q_valid;
            default: q_take = 1'b0;
        endcase
    end

    always_comb begin
        raw = '0;
        if (it_reg.gate)
            raw = (quo_reg >= DIVN_W'(top)) ? top : LVL_W'(quo_reg) + LVL_W'(1);
        elapsed = it_reg.now - dstart_reg;
        prod = 48'(decay_rate) * 48'(elapsed);
        dec = 41'((49'(prod) + 49'd255) >> 8);
        cur = sm_reg;
        nd = decaying_reg;
        nds = dstart_reg;
        if (raw >= cur) begin
            if (raw - cur > LVL_W'(5)) begin
                cur = cur + LVL_W'(5);
                if (cur > top) cur = top;
            end
            else cur = raw;
            nd = 1'b0;
            nds = '0;
        end
        else if (!decaying_reg) begin
            nd = 1'b1;
            nds = it_reg.now;
        end
        else if (elapsed >= 32'(decay_hold_ms) && cur <= LVL_W'(5)) begin
            cur = '0;
            nd = 1'b0;
            nds = '0;
        end
        else begin
            lvl_c = (dec >= 41'(cur)) ? '0 : cur - LVL_W'(dec);
            if (lvl_c < raw) begin
                cur = raw;
                nd = 1'b0;
                nds = '0;
            end
            else cur = lvl_c;
        end
        lvl_c = cur;
        ns = lvl_c == '0;
        vis_c = (lvl_c < last_reg) ? held_reg : it_reg.vis;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg <= ST_IDLE;
            cnt_reg <= '0;
            sm_reg <= '0;
            dstart_reg <= '0;
            decaying_reg <= 1'b0;
            last_reg <= '0;
            held_reg <= VIS_AH;
            full_out_reg <= 1'b0;
        end
        else begin
            st_reg <= st_next;
            if (out_load) full_out_reg <= 1'b1;
            else if (pop && full_out_reg) full_out_reg <= 1'b0;
            if (st_reg == ST_IDLE) cnt_reg <= '0;
            if (st_reg == ST_DIV) cnt_reg <= cnt_reg + CNT_W'(1);
            if (out_load) begin
                sm_reg <= lvl_c;
                decaying_reg <= nd;
                dstart_reg <= nds;
                last_reg <= lvl_c;
                if (!ns && lvl_c >= last_reg) held_reg <= it_reg.vis;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (q_take) begin
            it_reg <= q_item;
            quo_reg <= q_item.num;
            rem_reg <= '0;
        end
        else if (st_reg == ST_DIV) begin
            if (trial >= {1'b0, it_reg.den}) begin
                rem_reg <= trial - {1'b0, it_reg.den};
                quo_reg <= {quo_reg[DIVN_W-2:0], 1'b1};
            end
            else begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[DIVN_W-2:0], 1'b0};
            end
        end
        if (out_load) begin
            silent <= ns;
            viseme <= ns ? 3'd0 : vis_c;
            frame_row <= ns ? 4'd0 : 4'(lvl_c - LVL_W'(1));
            loudness <= 5'(lvl_c);
        end
    end

    assign empty = !full_out_reg;
endmodule
`default_nettype wire

### tb/sv/viseme_level_classifier_test.sv
// Self-checking testbench for the viseme level classifier: directed table, then random frames.
`timescale 1ns / 1ps
`default_nettype none
module viseme_level_classifier_test import vlc_pkg::*;;

    typedef struct packed {
        logic       silent;
        logic [2:0] viseme;
        logic [3:0] frame_row;
        logic [4:0] loudness;
    } mouth_t;

    typedef struct {
        logic [23:0] e [5];
        logic [31:0] now;
        bit          known;
        mouth_t      mouth;
    } frame_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [ENERGY_BITS-1:0] ah_energy = '0, ee_energy = '0, oh_energy = '0;
    logic [ENERGY_BITS-1:0] oo_energy = '0, th_energy = '0;
    logic [31:0] now_ms = '0;
    logic empty;
    logic pop = 1'b0;
    logic silent;
    logic [2:0] viseme;
    logic [3:0] frame_row;
    logic [4:0] loudness;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_NOISE;
    logic [25:0] cfg_data = '0;

    viseme_level_classifier DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    localparam int N_RANDOM = 850;

    // Shadow copy of the configuration and smoothing state.
    logic [25:0] gate_q;
    logic [4:0]  levels_q;
    logic [15:0] rate_q;
    logic [15:0] hold_q;
    logic [4:0]  level_q;
    logic [31:0] decay_from;
    bit          falling;
    logic [4:0]  prev_level;
    logic [2:0]  kept_viseme;

    mouth_t mouths_due [$];
    int errors = 0;
    int mismatches = 0;
    bit quiet_tail = 1'b0;
    logic [31:0] clock_ms = '0;

    function automatic mouth_t classify(input logic [23:0] e [5], input logic [31:0] now);
        logic [63:0] w [5];
        logic [63:0] sum, num, q;
        logic [63:0] d, dec;
        logic [4:0]  top, raw, lvl, cur, decayed;
        logic [2:0]  best, runner, vis;
        logic [31:0] elapsed;
        mouth_t      m;
        logic [9:0]  k [5];
        begin
            k[0] = 154; k[1] = 256; k[2] = 461; k[3] = 563; k[4] = 666;
            sum = 0;
            for (int i = 0; i < 5; i++)
            begin
                w[i] = 64'(e[i]) * 64'(k[i]);
                sum += w[i];
            end
            top = (levels_q < 1) ? 5'd1 : (levels_q > MAX_LEVELS) ? 5'(MAX_LEVELS) : levels_q;
            best = 0;
            for (int i = 1; i < 5; i++)
                if (w[i] > w[best]) best = 3'(i);
            vis = best;
            if (best == VIS_AH)
            begin
                runner = 1;
                for (int i = 2; i < 5; i++)
                    if (w[i] > w[runner]) runner = 3'(i);
                if (4 * w[runner] >= 3 * w[0]) vis = runner;
            end
            raw = 0;
            if (sum != 0 && w[best] > (64'(gate_q) << 8))
            begin
                num = 50 * w[best] - 6 * sum;
                q = (num * 64'(top - 1)) / (22 * sum);
                raw = (q >= top) ? top : 5'(q + 1);
            end
            cur = level_q;
            lvl = raw;
            if (lvl >= cur)
            begin
                if (lvl - cur > 5)
                begin
                    lvl = cur + 5'd5;
                    if (lvl > top) lvl = top;
                end
                cur = lvl;
                falling = 1'b0;
                decay_from = 0;
            end
            else if (!falling)
            begin
                falling = 1'b1;
                decay_from = now;
            end
            else
            begin
                elapsed = now - decay_from;
                if (elapsed >= hold_q && cur <= 5)
                begin
                    cur = 0;
                    falling = 1'b0;
                    decay_from = 0;
                end
                else
                begin
                    d = 64'(rate_q) * 64'(elapsed);
                    dec = (d + 255) >> 8;
                    decayed = (dec >= cur) ? 5'd0 : 5'(cur - dec);
                    if (decayed < lvl)
                    begin
                        cur = lvl;
                        falling = 1'b0;
                        decay_from = 0;
                    end
                    else
                        cur = decayed;
                end
            end
            level_q = cur;
            if (cur == 0)
            begin
                prev_level = 0;
                m = '{1'b1, 3'd0, 4'd0, 5'd0};
            end
            else
            begin
                if (cur < prev_level) vis = kept_viseme;
                else kept_viseme = vis;
                prev_level = cur;
                m = '{1'b0, vis, 4'(cur - 1), cur};
            end
            classify = m;
        end
    endfunction

    task automatic gap_burst();
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [25:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_NOISE:  gate_q = val;
            REG_LEVELS: levels_q = val[4:0];
            REG_RATE:   rate_q = val[15:0];
            default:    hold_q = val[15:0];
        endcase
    endtask

    task automatic drain();
        push <= 1'b0;
        while (mouths_due.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // The push line stays high after an accepted transaction so that frames can follow
    // back to back; an idle burst or a drain lowers it.
    task automatic send_frame(input logic [23:0] e [5], input logic [31:0] now,
                              input bit known, input mouth_t typed);
        mouth_t m;
        gap_burst();
        ah_energy <= e[0];
        ee_energy <= e[1];
        oh_energy <= e[2];
        oo_energy <= e[3];
        th_energy <= e[4];
        now_ms <= now;
        push <= 1'b1;
        do @(posedge clk); while (full);
        m = classify(e, now);
        if (known && m != typed)
        begin
            errors++;
            $display("table entry disagrees with prediction: %h vs %h", typed, m);
        end
        mouths_due.push_back(m);
    endtask

    function automatic logic [23:0] pick_energy();
        case ($urandom_range(0, 5))
            0:       pick_energy = 24'd0;
            1:       pick_energy = 24'hFFFFFF;
            2:       pick_energy = 24'($urandom_range(0, 255));
            default: pick_energy = 24'($urandom);
        endcase
    endfunction

    // Result side: random pop bursts and comparison against the oldest prediction.
    always @(posedge clk)
    begin
        mouth_t want;
        if (rst_n && pop && !empty)
        begin
            if (mouths_due.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result transaction");
            end
            else
            begin
                want = mouths_due.pop_front();
                if (silent !== want.silent || viseme !== want.viseme ||
                    frame_row !== want.frame_row || loudness !== want.loudness)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected s%0d v%0d r%0d l%0d, got s%0d v%0d r%0d l%0d",
                                 want.silent, want.viseme, want.frame_row, want.loudness,
                                 silent, viseme, frame_row, loudness);
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (!quiet_tail)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("[viseme_level_classifier] ERROR");
        $finish;
    end

    initial
    begin
        frame_row_t table_rows [$];
        frame_row_t r;
        logic [23:0] e [5];
        gate_q = 0; levels_q = 8; rate_q = 256; hold_q = 500;
        level_q = 0; decay_from = 0; falling = 0; prev_level = 0; kept_viseme = VIS_AH;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: silence, each band alone at full scale, ties, AH yielding, decay.
        r.known = 1; r.now = 0; r.e = '{0, 0, 0, 0, 0};
        r.mouth = '{1'b1, 3'd0, 4'd0, 5'd0}; table_rows.push_back(r);
        r.known = 0;
        for (int b = 0; b < 5; b++)
        begin
            r.e = '{0, 0, 0, 0, 0}; r.e[b] = 24'hFFFFFF; r.now = 10 * (b + 1);
            table_rows.push_back(r);
        end
        r.e = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}; r.now = 60;
        table_rows.push_back(r);
        r.e = '{1000, 462, 0, 0, 0}; r.now = 70; table_rows.push_back(r);
        r.e = '{1000, 400, 0, 0, 0}; r.now = 80; table_rows.push_back(r);
        r.e = '{0, 461, 256, 0, 0}; r.now = 90; table_rows.push_back(r);
        r.e = '{0, 0, 0, 0, 1}; r.now = 100; table_rows.push_back(r);
        r.e = '{1, 0, 0, 0, 0}; r.now = 400; table_rows.push_back(r);
        r.e = '{1, 1, 0, 0, 0}; r.now = 1000; table_rows.push_back(r);
        r.e = '{0, 0, 0, 0, 0}; r.now = 32'hFFFFFFF0; table_rows.push_back(r);
        r.e = '{0, 0, 0, 0, 0}; r.now = 32'h00000010; table_rows.push_back(r);
        r.e = '{5, 5, 5, 5, 5}; r.now = 20; table_rows.push_back(r);

        foreach (table_rows[i])
            send_frame(table_rows[i].e, table_rows[i].now, table_rows[i].known,
                       table_rows[i].mouth);
        drain();

        // Random phases through several register settings, extremes included.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_register(REG_LEVELS, 16); write_register(REG_RATE, 0);
                         write_register(REG_HOLD, 0); write_register(REG_NOISE, 0); end
                1: begin write_register(REG_LEVELS, 1); write_register(REG_RATE, 65535);
                         write_register(REG_HOLD, 65535); end
                2: begin write_register(REG_LEVELS, 0); write_register(REG_NOISE, 26'h3FFFFFF); end
                3: begin write_register(REG_LEVELS, 31); write_register(REG_NOISE, 26'h3FFFF); end
                4: begin write_register(REG_LEVELS, 5'($urandom_range(2, 16)));
                         write_register(REG_RATE, 16'($urandom_range(1, 600)));
                         write_register(REG_HOLD, 16'($urandom_range(0, 300)));
                         write_register(REG_NOISE, 26'($urandom_range(0, 4095))); end
                default: begin write_register(REG_LEVELS, 8); write_register(REG_RATE, 256);
                         write_register(REG_HOLD, 500); write_register(REG_NOISE, 0);
                         quiet_tail = 1'b1; end
            endcase
            for (int n = 0; n < N_RANDOM / 6; n++)
            begin
                for (int b = 0; b < 5; b++) e[b] = pick_energy();
                if ($urandom_range(0, 4) == 0) e = '{0, 0, 0, 0, 0};
                clock_ms += ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 120);
                send_frame(e, clock_ms, 1'b0, '0);
                if (phase == 1 && n == 40) drain();
            end
            drain();
        end
        if (errors == 0)
            $display("[viseme_level_classifier] OK");
        else
            $display("[viseme_level_classifier] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
design/vlc_pkg.sv
design/vlc_front.sv
design/vlc_back.sv
design/viseme_level_classifier.sv
tb/sv/viseme_level_classifier_test.sv
